FILE: sv/wpd_pkg.sv
// ----------------------------------------------------------------------------
// wpd_pkg: shared types and constants of the waypoint path densifier
// Holds the controller command and status words, the configuration register
// indexes and the arctangent table of the heading unit.
// ----------------------------------------------------------------------------
package wpd_pkg;

    // Configuration register indexes.
    localparam logic REG_STEP_LENGTH = 1'b0;
    localparam logic REG_SPEED       = 1'b1;

    localparam logic [30:0] STEP_LENGTH_RST = 31'd6554;
    localparam logic [30:0] SPEED_RST       = 31'd65536;

    // Heading unit: angles in units of 2^-24 rad.
    localparam int                 CORDIC_ITERS = 24;
    localparam logic signed [28:0] ANG_PI       = 29'sd52707179;
    localparam logic signed [28:0] YAW_MAX      = 29'sd25736;

    // Last iteration indexes of the shared step counter.
    localparam logic [5:0] ROOT_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'd31;

    typedef struct packed {
        logic load;
        logic sqr;
        logic sum;
        logic root_step;
        logic cnt_init;
        logic cnt_step;
        logic div_init;
        logic div_step;
        logic prep;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic root_last;
        logic cnt_done;
        logic div_last;
        logic emit_end;
    } t_status;

    function automatic logic signed [28:0] f_atan(input logic [4:0] i);
        logic signed [28:0] v;
        case (i)
            5'd0:    v = 29'sd13176795;
            5'd1:    v = 29'sd7778716;
            5'd2:    v = 29'sd4110060;
            5'd3:    v = 29'sd2086331;
            5'd4:    v = 29'sd1047214;
            5'd5:    v = 29'sd524117;
            5'd6:    v = 29'sd262123;
            5'd7:    v = 29'sd131069;
            5'd8:    v = 29'sd65536;
            5'd9:    v = 29'sd32768;
            5'd10:   v = 29'sd16384;
            5'd11:   v = 29'sd8192;
            5'd12:   v = 29'sd4096;
            5'd13:   v = 29'sd2048;
            5'd14:   v = 29'sd1024;
            5'd15:   v = 29'sd512;
            5'd16:   v = 29'sd256;
            5'd17:   v = 29'sd128;
            5'd18:   v = 29'sd64;
            5'd19:   v = 29'sd32;
            5'd20:   v = 29'sd16;
            5'd21:   v = 29'sd8;
            5'd22:   v = 29'sd4;
            5'd23:   v = 29'sd2;
            default: v = 29'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/wpd_ctrl.sv
// ----------------------------------------------------------------------------
// wpd_ctrl: sequencing state machine of the waypoint path densifier
// Steps the datapath through square, root, count, divide and emit phases
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module wpd_ctrl
    import wpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQR   = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_ROOT  = 8'b0000_1000,
        S_COUNT = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_PREP  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_out_free;

    assign w_out_free  = !r_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQR;
                end
            end
            S_SQR: begin
                if (i_st.skip) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.sqr = 1'b1;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_st.root_last) begin
                    o_cmd.cnt_init = 1'b1;
                    n_state        = S_COUNT;
                end
            end
            S_COUNT: begin
                if (i_st.cnt_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_st.div_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.emit_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_valid = o_cmd.emit ? 1'b1 : (i_out_stall ? r_valid : 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: sv/wpd_dpath.sv
// ----------------------------------------------------------------------------
// wpd_dpath: datapath of the waypoint path densifier
// Segment deltas, squared length and its root, step count search, heading
// rotation unit, per-axis quotient divider and the point stepping logic.
// ----------------------------------------------------------------------------
module wpd_dpath
    import wpd_pkg::*;
#(
    parameter int MAX_STEPS = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_st,
    input  logic               i_start_path,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic [30:0]        i_step_length,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [15:0] o_yaw,
    output logic               o_last
);

    localparam int N_W = $clog2(MAX_STEPS + 1);

    logic                     r_have;
    logic signed [31:0]       r_prev_x, r_prev_y, r_pt_x, r_pt_y;
    logic signed [31:0]       r_pos_x, r_pos_y;
    logic signed [32:0]       r_dx, r_dy;
    logic                     r_skip;
    logic [63:0]              r_sqx, r_sqy;
    logic [65:0]              r_dsh;
    logic [36:0]              r_rem;
    logic [32:0]              r_root;
    logic [5:0]               r_it;
    logic signed [35:0]       r_cx, r_cy;
    logic signed [28:0]       r_cz;
    logic                     r_cflat;
    logic [36:0]              r_acc;
    logic [N_W-1:0]           r_n, r_k;
    logic [31:0]              r_qx, r_qy;
    logic [N_W-1:0]           r_rx, r_ry;
    logic [31:0]              r_stx, r_sty;
    logic [N_W:0]             r_rsx, r_rsy;
    logic [N_W+1:0]           r_dax, r_day;
    logic signed [15:0]       r_yaw;
    logic signed [31:0]       r_ox, r_oy;
    logic signed [15:0]       r_oyaw;
    logic                     r_olast;

    logic [32:0]              w_ax, w_ay;
    logic [36:0]              w_rsh, w_trial;
    logic [33:0]              w_c;
    logic signed [35:0]       w_dx36, w_dy36, w_xs, w_ys;
    logic signed [28:0]       w_zr;
    logic signed [15:0]       w_yaw;
    logic [N_W:0]             w_tx, w_ty, w_n1;
    logic [N_W+1:0]           w_sx, w_sy, w_2n;
    logic                     w_hx, w_hy;
    logic                     w_skip;

    assign w_ax = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_ay = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);

    // Square root, two bits of the radicand per step.
    assign w_rsh   = {r_rem[34:0], r_dsh[65:64]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_c     = {1'b0, r_root} + 34'(r_rem != 37'd0);

    assign w_dx36 = 36'(r_dx);
    assign w_dy36 = 36'(r_dy);
    assign w_xs   = r_cx >>> r_it[4:0];
    assign w_ys   = r_cy >>> r_it[4:0];

    always_comb begin
        w_zr = (r_cz + 29'sd1024) >>> 11;
        if (w_zr > YAW_MAX) begin
            w_yaw = 16'(YAW_MAX);
        end else if (w_zr < -YAW_MAX) begin
            w_yaw = 16'(-YAW_MAX);
        end else begin
            w_yaw = 16'(w_zr);
        end
    end

    // Restoring divide of the absolute deltas by the step count.
    assign w_n1 = {1'b0, r_n};
    assign w_tx = {r_rx, r_qx[31]};
    assign w_ty = {r_ry, r_qy[31]};

    // Rounded point stepping: remainder kept in [0, 2n).
    assign w_2n = {1'b0, r_n, 1'b0};
    assign w_sx = r_dax + {1'b0, r_rsx};
    assign w_sy = r_day + {1'b0, r_rsy};
    assign w_hx = (w_sx >= w_2n);
    assign w_hy = (w_sy >= w_2n);

    assign w_skip = i_start_path || !r_have
                    || (i_point_x == r_prev_x && i_point_y == r_prev_y);

    assign o_st.skip      = r_skip;
    assign o_st.root_last = (r_it == ROOT_LAST);
    assign o_st.div_last  = (r_it == DIV_LAST);
    assign o_st.cnt_done  = (r_acc >= {3'b000, w_c}) || (r_n == N_W'(MAX_STEPS));
    assign o_st.emit_end  = r_skip || (r_k == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (i_cmd.load) begin
            r_have   <= 1'b1;
            r_prev_x <= i_point_x;
            r_prev_y <= i_point_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt_x  <= i_point_x;
            r_pt_y  <= i_point_y;
            r_dx    <= 33'(i_point_x) - 33'(r_prev_x);
            r_dy    <= 33'(i_point_y) - 33'(r_prev_y);
            r_skip  <= w_skip;
            r_pos_x <= r_prev_x;
            r_pos_y <= r_prev_y;
        end

        if (i_cmd.sqr) begin
            r_sqx <= w_ax[31:0] * w_ax[31:0];
            r_sqy <= w_ay[31:0] * w_ay[31:0];
            // Pre-rotate the left half plane through plus or minus pi.
            r_cx  <= r_dx[32] ? -w_dx36 : w_dx36;
            r_cy  <= r_dx[32] ? -w_dy36 : w_dy36;
            r_cz  <= r_dx[32] ? (r_dy[32] ? -ANG_PI : ANG_PI) : 29'sd0;
            r_cflat <= (r_dy == 33'sd0);
        end

        if (i_cmd.sum || i_cmd.div_init) begin
            r_it <= '0;
        end else if (i_cmd.root_step || i_cmd.div_step) begin
            r_it <= r_it + 6'd1;
        end

        if (i_cmd.sum) begin
            r_dsh  <= {2'b00, r_sqx} + {2'b00, r_sqy};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_dsh <= {r_dsh[63:0], 2'b00};
            if (w_rsh >= w_trial) begin
                r_rem  <= w_rsh - w_trial;
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= w_rsh;
                r_root <= {r_root[31:0], 1'b0};
            end
        end

        // The heading unit shares the root phase and finishes first.
        if (i_cmd.root_step && !r_cflat && (r_it < 6'(CORDIC_ITERS))) begin
            if (!r_cy[35]) begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + f_atan(r_it[4:0]);
            end else begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - f_atan(r_it[4:0]);
            end
        end

        if (i_cmd.cnt_init) begin
            r_acc <= {6'd0, i_step_length};
            r_n   <= N_W'(1);
        end else if (i_cmd.cnt_step) begin
            r_acc <= r_acc + {6'd0, i_step_length};
            r_n   <= r_n + N_W'(1);
        end

        if (i_cmd.div_init) begin
            r_qx <= w_ax[31:0];
            r_qy <= w_ay[31:0];
            r_rx <= '0;
            r_ry <= '0;
        end else if (i_cmd.div_step) begin
            if (w_tx >= w_n1) begin
                r_rx <= N_W'(w_tx - w_n1);
                r_qx <= {r_qx[30:0], 1'b1};
            end else begin
                r_rx <= N_W'(w_tx);
                r_qx <= {r_qx[30:0], 1'b0};
            end
            if (w_ty >= w_n1) begin
                r_ry <= N_W'(w_ty - w_n1);
                r_qy <= {r_qy[30:0], 1'b1};
            end else begin
                r_ry <= N_W'(w_ty);
                r_qy <= {r_qy[30:0], 1'b0};
            end
        end

        if (i_cmd.prep) begin
            // Floor quotient and remainder of the signed delta.
            if (r_dx[32]) begin
                r_stx <= (r_rx == '0) ? -r_qx : ~r_qx;
                r_rsx <= (r_rx == '0) ? '0 : {r_n - r_rx, 1'b0};
            end else begin
                r_stx <= r_qx;
                r_rsx <= {r_rx, 1'b0};
            end
            if (r_dy[32]) begin
                r_sty <= (r_ry == '0) ? -r_qy : ~r_qy;
                r_rsy <= (r_ry == '0) ? '0 : {r_n - r_ry, 1'b0};
            end else begin
                r_sty <= r_qy;
                r_rsy <= {r_ry, 1'b0};
            end
            r_dax <= (N_W+2)'(r_n);
            r_day <= (N_W+2)'(r_n);
            r_k   <= '0;
            r_yaw <= w_yaw;
        end

        if (i_cmd.emit) begin
            if (r_skip || r_k == r_n) begin
                r_ox    <= r_pt_x;
                r_oy    <= r_pt_y;
                r_oyaw  <= r_skip ? 16'sd0 : r_yaw;
                r_olast <= 1'b1;
            end else begin
                r_dax   <= w_hx ? w_sx - w_2n : w_sx;
                r_day   <= w_hy ? w_sy - w_2n : w_sy;
                r_pos_x <= r_pos_x + r_stx + 32'(w_hx);
                r_pos_y <= r_pos_y + r_sty + 32'(w_hy);
                r_ox    <= r_pos_x + r_stx + 32'(w_hx);
                r_oy    <= r_pos_y + r_sty + 32'(w_hy);
                r_oyaw  <= r_yaw;
                r_olast <= 1'b0;
                r_k     <= r_k + N_W'(1);
            end
        end
    end

    assign o_x    = r_ox;
    assign o_y    = r_oy;
    assign o_yaw  = r_oyaw;
    assign o_last = r_olast;

endmodule

FILE: sv/waypoint_path_densifier_core.sv
// ----------------------------------------------------------------------------
// waypoint_path_densifier_core: densifies a 2D waypoint path
// Each waypoint is joined to the previous one; evenly spaced points along the
// segment are emitted with the segment heading, followed by the waypoint.
// ----------------------------------------------------------------------------
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+--------------------------------------
//  input    | i_in_valid  | o_in_stall   | i_start_path, i_point_x, i_point_y
//  output   | o_out_valid | i_out_stall  | o_out_x, o_out_y, o_out_speed,
//           |             |              | o_out_yaw, o_last_of_run
//  config   | i_cfg_we    | (none)       | i_cfg_idx, i_cfg_data
//
// A path start, the first point after reset or a repeated point skips to emit and delivers one word.
// Any other waypoint passes through load, square and sum, 33 square-root steps
// (the heading rotation runs alongside), c count steps (1 to MAX_STEPS, equal
// to n) of the step-length accumulator, 32 steps of the quotient divider and a
// prepare step, then one word per emitted point.
// Reset is synchronous and active low; it clears the previous point and
// loads the configuration defaults. A stalled output holds only the emit
// phase; the next input word is taken once the last word is registered.
// ----------------------------------------------------------------------------
module waypoint_path_densifier_core
    import wpd_pkg::*;
#(
    parameter int MAX_STEPS = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_start_path,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic [30:0]        o_out_speed,
    output logic signed [15:0] o_out_yaw,
    output logic               o_last_of_run
);

    logic [30:0] r_step_length;
    logic [30:0] r_speed;
    t_cmd        w_cmd;
    t_status     w_st;

    // Config registers; the user's writes must arrive only while the block is idle; no check enforces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_length <= STEP_LENGTH_RST;
            r_speed       <= SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_LENGTH: r_step_length <= i_cfg_data;
                REG_SPEED:       r_speed       <= i_cfg_data;
                default:         r_speed       <= r_speed;
            endcase
        end
    end

    // The speed register is stable while words are in flight as long as the user writes it only while idle.
    assign o_out_speed = r_speed;

    wpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    wpd_dpath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .i_start_path  (i_start_path),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_step_length (r_step_length),
        .o_x           (o_out_x),
        .o_y           (o_out_y),
        .o_yaw         (o_out_yaw),
        .o_last        (o_last_of_run)
    );

    // An accepted word closes the input until its run is finished.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted word");

    // A new point is loaded only into a free or draining output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // The closing emit of a run carries the waypoint flag.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_st.emit_end) |=> (o_out_valid && o_last_of_run))
        else $error("run ended without the waypoint flag");

    // Loads happen only while the input channel is open.
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in_valid && !o_in_stall))
        else $error("load without an accepted word");

endmodule
